/* rtl/core/xoroshiro1024_star_prng_core_macros.svh */
// Assertion macros shared by the checker of the xoroshiro1024* core.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef XOROSHIRO1024_STAR_PRNG_CORE_MACROS_SVH
`define XOROSHIRO1024_STAR_PRNG_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define XS1K_CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define XS1K_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define XS1K_CHK_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/xs1k_pkg.sv */
// Types, constants and helper functions of the xoroshiro1024* core.
// No dependencies; every module and interface of the core imports it.
`default_nettype none

package xs1k_pkg;

    localparam int unsigned NUM_WORDS = 16;
    localparam int unsigned WORD_W    = 64;
    localparam int unsigned POS_W     = 4;
    localparam int unsigned HALF_W    = WORD_W / 2;

    localparam logic [WORD_W-1:0] GOLDEN_MUL = 64'h9e37_79b9_7f4a_7c13;
    localparam int unsigned ROT_A   = 25;
    localparam int unsigned SHIFT_B = 27;
    localparam int unsigned ROT_C   = 36;

    localparam logic CMD_GENERATE = 1'b0;
    localparam logic CMD_LOAD     = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [POS_W-1:0]  t_pos;

    // Per-cell control: shift takes the neighbor's word, load takes the seed.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    // Self-test seed held by state word k after reset.
    function automatic t_word init_word(input t_pos k);
        t_word w;
        case (k)
            t_pos'(0): w = 64'h1234_5678_9ABC_DEF0;
            t_pos'(1): w = 64'hDEAD_BEEF_DEAD_BEEF;
            default:   w = t_word'(69069) * t_word'(k);
        endcase
        return w;
    endfunction

    function automatic t_word rotl(input t_word x, input int unsigned k);
        return (x << k) | (x >> (WORD_W - k));
    endfunction

endpackage

`default_nettype wire

/* rtl/core/xs1k_ifs.sv */
// Request and response channel interfaces of the xoroshiro1024* core.
// Depends on xs1k_pkg for the payload types.
`default_nettype none

interface xs1k_req_if;
    import xs1k_pkg::*;

    logic  valid;
    logic  ready;
    logic  command;
    t_pos  word_index;
    t_word seed_word;

    modport source (output valid, output command, output word_index, output seed_word,
                    input ready);
    modport sink   (input valid, input command, input word_index, input seed_word,
                    output ready);
endinterface

interface xs1k_rsp_if;
    import xs1k_pkg::*;

    logic  valid;
    logic  ready;
    t_word random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

`default_nettype wire

/* rtl/core/xs1k_cell.sv */
// One 64-bit state cell of the generator ring.
// Depends on xs1k_pkg for the word and control types.
`default_nettype none

module xs1k_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xs1k_pkg::t_word    i_init_word,
    input  xs1k_pkg::t_cell_ctl i_ctl,
    input  xs1k_pkg::t_word    i_shift_word,
    input  xs1k_pkg::t_word    i_load_word,
    output xs1k_pkg::t_word    o_word
);
    import xs1k_pkg::*;

    t_word r_word;
    t_word n_word;

    always_comb begin
        n_word = r_word;
        if (i_ctl.load) begin
            n_word = i_load_word;
        end else if (i_ctl.shift) begin
            n_word = i_shift_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= i_init_word;
        end else begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

/* rtl/core/xs1k_mul.sv */
// Two-stage output scrambler: multiplies s0 by the golden-ratio constant
// modulo 2^64 from 32-bit partial products. Depends on xs1k_pkg, xs1k_ifs.
`default_nettype none

module xs1k_mul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  xs1k_pkg::t_word i_s0,
    output logic            o_ready,
    xs1k_rsp_if.source      o_rsp
);
    import xs1k_pkg::*;

    localparam logic [HALF_W-1:0] MUL_LO = GOLDEN_MUL[HALF_W-1:0];
    localparam logic [HALF_W-1:0] MUL_HI = GOLDEN_MUL[WORD_W-1:HALF_W];

    logic              r_v1;
    logic [WORD_W-1:0] r_p00;
    logic [HALF_W-1:0] r_p01;
    logic [HALF_W-1:0] r_p10;
    logic              r_v2;
    t_word             r_out;

    logic              w_en1;
    logic              w_en2;
    logic [WORD_W-1:0] n_p00;
    logic [HALF_W-1:0] n_p01;
    logic [HALF_W-1:0] n_p10;
    logic [HALF_W-1:0] w_cross;

    assign w_en2   = !r_v2 || o_rsp.ready;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    // Only the low half of the cross products reaches the low 64 bits.
    assign n_p00   = WORD_W'(i_s0[HALF_W-1:0]) * WORD_W'(MUL_LO);
    assign n_p01   = HALF_W'(i_s0[HALF_W-1:0] * MUL_HI);
    assign n_p10   = HALF_W'(i_s0[WORD_W-1:HALF_W] * MUL_LO);
    assign w_cross = r_p01 + r_p10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) begin
            r_p00 <= n_p00;
            r_p01 <= n_p01;
            r_p10 <= n_p10;
        end
        if (w_en2 && r_v1) begin
            r_out <= r_p00 + {w_cross, {HALF_W{1'b0}}};
        end
    end

    assign o_rsp.valid        = r_v2;
    assign o_rsp.random_value = r_out;

endmodule

`default_nettype wire

/* rtl/core/xoroshiro1024_star_prng_core.sv */
// xoroshiro1024* generator core: ring of sixteen state cells plus scrambler.
// Depends on xs1k_pkg, xs1k_ifs, xs1k_cell and xs1k_mul.
//
// Usage:
//   i_req carries requests: command 0 generates one value, command 1 writes
//   seed_word into state word word_index and returns the position to zero.
//   o_rsp carries one random_value for each generate request, in order.
//   Generate requests are taken one per cycle while the ring is aligned
//   and o_rsp is not stalled. Once accepted, a request's result passes
//   through a two-stage multiplier whose last stage is the output register.
//   The state sits in a ring of cells kept rotated so that the current word
//   is always in cell 0; a generate shifts the ring by one cell. A load
//   leaves the ring rotated, so after it i_req.ready stays low while the
//   ring turns back, until the ring offset wraps to zero.
//   Reset (synchronous, active low) restores the self-test seed, sets the
//   position to zero and empties the output pipeline.
//   When the receiver holds o_rsp.ready low, the result waits in the output
//   register, one more request fills the first stage, then i_req.ready drops.
`default_nettype none

module xoroshiro1024_star_prng_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    xs1k_req_if.sink  i_req,
    xs1k_rsp_if.source o_rsp
);
    import xs1k_pkg::*;

    t_pos  r_base;
    logic  r_realign;
    t_pos  n_base;
    logic  n_realign;

    t_word     w_word  [NUM_WORDS];
    t_word     w_shift [NUM_WORDS];
    t_cell_ctl w_ctl   [NUM_WORDS];

    logic  w_mul_ready;
    logic  w_busy;
    logic  w_acc;
    logic  w_gen;
    logic  w_load;
    t_pos  w_target;
    t_word w_s0;
    t_word w_s15;
    t_word w_t;
    t_word w_old_next;
    t_word w_new_next;

    // Cell k holds state word (r_base + k) mod 16.
    assign w_busy      = r_realign && (r_base != '0);
    assign i_req.ready = w_mul_ready && !w_busy;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_gen       = w_acc && (i_req.command == CMD_GENERATE);
    assign w_load      = w_acc && (i_req.command == CMD_LOAD);
    assign w_target    = i_req.word_index - r_base;

    assign w_s15      = w_word[0];
    assign w_s0       = w_word[1];
    assign w_t        = w_s15 ^ w_s0;
    assign w_old_next = rotl(w_s0, ROT_A) ^ w_t ^ (w_t << SHIFT_B);
    assign w_new_next = rotl(w_t, ROT_C);

    for (genvar gi = 0; gi < NUM_WORDS; gi++) begin : g_cell
        assign w_ctl[gi].shift = w_gen || w_busy;
        assign w_ctl[gi].load  = w_load && (w_target == t_pos'(gi));

        if (gi == 0) begin : g_head
            assign w_shift[gi] = w_gen ? w_new_next : w_word[1];
        end else if (gi == NUM_WORDS - 1) begin : g_tail
            assign w_shift[gi] = w_gen ? w_old_next : w_word[0];
        end else begin : g_mid
            assign w_shift[gi] = w_word[gi + 1];
        end

        xs1k_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_init_word  (init_word(t_pos'(gi))),
            .i_ctl        (w_ctl[gi]),
            .i_shift_word (w_shift[gi]),
            .i_load_word  (i_req.seed_word),
            .o_word       (w_word[gi])
        );
    end

    always_comb begin
        n_base    = r_base;
        n_realign = r_realign;
        if (w_gen || w_busy) begin
            n_base = r_base + t_pos'(1);
        end
        if (w_load) begin
            n_realign = (r_base != '0);
        end else if (w_busy) begin
            // The ring is aligned once the offset wraps to zero.
            n_realign = (r_base != '1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_realign <= 1'b0;
        end else begin
            r_base    <= n_base;
            r_realign <= n_realign;
        end
    end

    xs1k_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_gen),
        .i_s0    (w_s0),
        .o_ready (w_mul_ready),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

/* rtl/core/xoroshiro1024_star_prng_core_chk.sv */
// Port-level checker of the xoroshiro1024* core and its bind statement.
// Depends on xoroshiro1024_star_prng_core_macros.svh and the core's ports.
`default_nettype none

`include "xoroshiro1024_star_prng_core_macros.svh"

module xoroshiro1024_star_prng_core_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_valid,
    input wire logic        i_req_ready,
    input wire logic        i_req_command,
    input wire logic        i_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic [63:0] i_rsp_random_value
);
    import xs1k_pkg::*;

    logic w_acc_gen;

    assign w_acc_gen = i_req_valid && i_req_ready && (i_req_command == CMD_GENERATE);

    // A stalled result stays offered and unchanged.
    `XS1K_CHK_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_random_value), "stalled result changed or dropped")

    // A result that appears in an empty output stage comes from a generate
    // request taken into the first multiplier stage and passed on without a stall.
    `XS1K_CHK_SAME(a_rsp_origin, $rose(i_rsp_valid), $past(w_acc_gen, 2), "result without a generate request")

    // Reset empties the output register.
    `XS1K_CHK_ALWAYS(a_rst_empty, !i_rst_n, !i_rsp_valid, "output valid after reset")

endmodule

bind xoroshiro1024_star_prng_core xoroshiro1024_star_prng_core_chk u_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_req_valid        (i_req.valid),
    .i_req_ready        (i_req.ready),
    .i_req_command      (i_req.command),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_random_value (o_rsp.random_value)
);

`default_nettype wire

/* tb/tb_xoroshiro1024_star_prng_core.sv */
// Self-checking testbench for the xoroshiro1024* generator core.
// Depends on xs1k_pkg, xs1k_ifs and the core; predicts every random value
// in a behavioral copy of the generator and checks it against the core.
`timescale 1ns / 1ps

module tb_xoroshiro1024_star_prng_core;
    import xs1k_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned TARGET_ITEMS = 1000;
    localparam int unsigned IDLE_PCT     = 22;
    localparam int unsigned DRAIN_CYCLES = 20;

    logic i_clk;
    logic i_rst_n;

    xs1k_req_if req_bus ();
    xs1k_rsp_if rsp_bus ();

    xoroshiro1024_star_prng_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Behavioral copy of the generator state.
    t_word gen_words [NUM_WORDS];
    t_pos  gen_pos;

    t_word expected_values [$];

    bit    sender_idles   = 1'b1;
    bit    receiver_idles = 1'b1;
    int    item_count     = 0;
    int    generate_count = 0;
    int    load_count     = 0;
    int    checked_count  = 0;
    int    error_count    = 0;
    int    cycle_count    = 0;
    t_word oldest_value;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_xoroshiro1024_star_prng_core: errors");
            $finish;
        end
    end

    function automatic void reset_generator();
        gen_words[0] = 64'h1234_5678_9ABC_DEF0;
        gen_words[1] = 64'hDEAD_BEEF_DEAD_BEEF;
        for (int i = 2; i < NUM_WORDS; i++) begin
            gen_words[i] = 64'd69069 * i;
        end
        gen_pos = '0;
    endfunction

    // One generator step: returns the scrambled value and updates two words.
    function automatic t_word step_generator();
        t_pos  cur_pos;
        t_pos  next_pos;
        t_word s0;
        t_word mix;
        cur_pos  = gen_pos;
        next_pos = cur_pos + 1'b1;
        s0       = gen_words[next_pos];
        mix      = gen_words[cur_pos] ^ s0;
        gen_words[cur_pos] = {s0[WORD_W-ROT_A-1:0], s0[WORD_W-1:WORD_W-ROT_A]}
                             ^ mix ^ (mix << SHIFT_B);
        gen_words[next_pos] = {mix[WORD_W-ROT_C-1:0], mix[WORD_W-1:WORD_W-ROT_C]};
        gen_pos = next_pos;
        return s0 * GOLDEN_MUL;
    endfunction

    function automatic t_word random_word();
        int unsigned pick;
        pick = $urandom_range(15);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return '1;
        end
        return {$urandom, $urandom};
    endfunction

    // Drives one request and holds it until the core takes it. Valid stays
    // high on return so that a following request can go out back to back.
    task automatic send_request(input logic cmd, input t_pos idx, input t_word seed);
        int gap;
        gap = 0;
        if (sender_idles) begin
            while ($urandom_range(99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.command    <= cmd;
        req_bus.word_index <= idx;
        req_bus.seed_word  <= seed;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        item_count++;
        if (cmd == CMD_LOAD) begin
            gen_words[idx] = seed;
            gen_pos        = '0;
            load_count++;
        end else begin
            expected_values.push_back(step_generator());
            generate_count++;
        end
    endtask

    // The index and seed of a generate request are don't-care, so they get noise.
    task automatic request_generate();
        send_request(CMD_GENERATE, t_pos'($urandom_range(15)), {$urandom, $urandom});
    endtask

    task automatic request_load(input t_pos idx, input t_word seed);
        send_request(CMD_LOAD, idx, seed);
    endtask

    task automatic reseed_all(input bit zero_fill);
        for (int i = 0; i < NUM_WORDS; i++) begin
            request_load(t_pos'(i), zero_fill ? t_word'(0) : random_word());
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= !receiver_idles || ($urandom_range(99) >= IDLE_PCT);
        end
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_values.size() == 0) begin
                $error("random_value: unexpected result %h", rsp_bus.random_value);
                error_count++;
            end else begin
                oldest_value = expected_values.pop_front();
                checked_count++;
                if (rsp_bus.random_value !== oldest_value) begin
                    $error("random_value mismatch: expected %h, actual %h",
                           oldest_value, rsp_bus.random_value);
                    error_count++;
                end
            end
        end
    end

    // Values straight from the power-on seed, with extreme index and seed fields.
    task automatic test_reset_seed();
        send_request(CMD_GENERATE, t_pos'(0), t_word'(0));
        send_request(CMD_GENERATE, t_pos'(15), '1);
        send_request(CMD_GENERATE, t_pos'(15), t_word'(0));
        send_request(CMD_GENERATE, t_pos'(0), '1);
    endtask

    // A load returns the position to zero even when it writes another word.
    task automatic test_load_position();
        request_generate();
        request_generate();
        request_load(t_pos'(9), '1);
        repeat (3) request_generate();
        request_load(t_pos'(0), t_word'(0));
        request_generate();
        request_load(t_pos'(15), 64'h8000_0000_0000_0001);
        request_generate();
        request_generate();
    endtask

    // Full throughput with neither side idling, across a ring realignment.
    task automatic test_back_to_back();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        repeat (100) request_generate();
        request_load(t_pos'($urandom_range(15)), random_word());
        repeat (100) request_generate();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    // An all-zero state must keep producing zeros until it is reseeded.
    task automatic test_zero_state();
        reseed_all(1'b1);
        repeat (20) request_generate();
        reseed_all(1'b0);
        repeat (20) request_generate();
    endtask

    task automatic test_random_mix();
        int unsigned pick;
        while (item_count < TARGET_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                repeat ($urandom_range(40, 1)) request_generate();
            end else if (pick < 92) begin
                request_load(t_pos'($urandom_range(15)), random_word());
            end else begin
                reseed_all(1'b0);
            end
        end
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.command    <= CMD_GENERATE;
        req_bus.word_index <= '0;
        req_bus.seed_word  <= '0;
        reset_generator();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_seed();
        test_load_position();
        test_back_to_back();
        test_zero_state();
        test_random_mix();

        req_bus.valid <= 1'b0;
        while (expected_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d generate and %0d load requests; %0d values compared.",
                 generate_count, load_count, checked_count);
        $display("It included the power-on seed, an all-zero state and a no-stall burst.");
        if (error_count == 0) begin
            $display("tb_xoroshiro1024_star_prng_core: clean");
        end else begin
            $display("tb_xoroshiro1024_star_prng_core: errors");
        end
        $finish;
    end

endmodule
